>>> hw/rtl/p3at_pkg.sv
package p3at_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT = 24;

  // Angle path is Q.30 with headroom for the +-8 rad input range
  localparam int ANG_W = 36;
  // CORDIC x/y datapath, Q.30 with growth room
  localparam int CS_W  = 34;
  // Point minus reference, full width
  localparam int PT_W  = 33;
  // Product width of a PT_W by 32 bit multiply
  localparam int PR_W  = 65;
  // Pre-saturation coordinate width
  localparam int Q_W   = 50;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CS_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CS_W-1:0]  ONE_Q30     = 34'sd1073741824;

  typedef enum logic [3:0] {
    OP_TRANSLATE = 4'd0,
    OP_ROT_X     = 4'd1,
    OP_ROT_Y     = 4'd2,
    OP_ROT_Z     = 4'd3,
    OP_SCALE     = 4'd4,
    OP_REL_ROT_X = 4'd5,
    OP_REL_ROT_Y = 4'd6,
    OP_REL_ROT_Z = 4'd7,
    OP_REL_SCALE = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    MODE_PASS,
    MODE_ADD,
    MODE_ROT_X,
    MODE_ROT_Y,
    MODE_ROT_Z,
    MODE_SCALE
  } mode_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] operand_x;
    logic signed [31:0] operand_y;
    logic signed [31:0] operand_z;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [19:0] angle;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
  } res_t;

  // Per-beat payload carried alongside the CORDIC
  typedef struct packed {
    mode_t                 mode;
    logic                  rel;
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic signed [PT_W-1:0] pz;
    logic signed [31:0]    ox;
    logic signed [31:0]    oy;
    logic signed [31:0]    oz;
    logic signed [31:0]    rx;
    logic signed [31:0]    ry;
    logic signed [31:0]    rz;
  } payload_t;

  function automatic int cordic_depth(input int steps);
    return (steps < ATAN_COUNT) ? steps : ATAN_COUNT;
  endfunction

  // Total latency from accept to result strobe
  function automatic int core_latency(input int steps);
    return cordic_depth(steps) + 6;
  endfunction

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/point3d_affine_transform_core.sv
// 3D point affine transform, fully pipelined. A point is taken on every
// cycle that start is high; busy is always low since nothing inside can
// back up. The result appears on out_res with out_valid high for exactly
// one cycle, after the beat has run through these stages (the step count
// is capped at 24): one input register, one angle-fold stage, one CORDIC
// stage per step plus a clamp stage, then multiply, round and saturate
// stages. Results come out in order, one per accepted beat, and must be
// captured when out_valid is high since the core cannot hold them.
module point3d_affine_transform_core #(
  parameter int CORDIC_STEPS = p3at_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  p3at_pkg::in_req_t in_req,
  output logic              out_valid,
  output p3at_pkg::res_t    out_res
);
  import p3at_pkg::*;

  localparam int DLY = cordic_depth(CORDIC_STEPS) + 1;

  // Never stall the source
  assign busy = 1'b0;

  // ---- Stage 0: decode, subtract reference, first angle wrap ----
  payload_t               pl_nxt;
  logic signed [ANG_W-1:0] a0;
  logic signed [ANG_W-1:0] a1_nxt;

  always_comb begin
    pl_nxt.mode = MODE_PASS;
    pl_nxt.rel  = 1'b0;
    case (in_req.req_type) inside
      OP_TRANSLATE:               pl_nxt.mode = MODE_ADD;
      OP_ROT_X, OP_REL_ROT_X:     pl_nxt.mode = MODE_ROT_X;
      OP_ROT_Y, OP_REL_ROT_Y:     pl_nxt.mode = MODE_ROT_Y;
      OP_ROT_Z, OP_REL_ROT_Z:     pl_nxt.mode = MODE_ROT_Z;
      OP_SCALE, OP_REL_SCALE:     pl_nxt.mode = MODE_SCALE;
      default:                    pl_nxt.mode = MODE_PASS;
    endcase
    case (in_req.req_type) inside
      OP_REL_ROT_X, OP_REL_ROT_Y, OP_REL_ROT_Z, OP_REL_SCALE: pl_nxt.rel = 1'b1;
      default: pl_nxt.rel = 1'b0;
    endcase
    // relative ops work on the point minus the reference, at full width
    if (pl_nxt.rel) begin
      pl_nxt.px = PT_W'(in_req.point_x) - PT_W'(in_req.ref_x);
      pl_nxt.py = PT_W'(in_req.point_y) - PT_W'(in_req.ref_y);
      pl_nxt.pz = PT_W'(in_req.point_z) - PT_W'(in_req.ref_z);
    end else begin
      pl_nxt.px = PT_W'(in_req.point_x);
      pl_nxt.py = PT_W'(in_req.point_y);
      pl_nxt.pz = PT_W'(in_req.point_z);
    end
    pl_nxt.ox = in_req.operand_x;
    pl_nxt.oy = in_req.operand_y;
    pl_nxt.oz = in_req.operand_z;
    pl_nxt.rx = in_req.ref_x;
    pl_nxt.ry = in_req.ref_y;
    pl_nxt.rz = in_req.ref_z;

    // Q3.16 to Q.30, then wrap into [-pi, pi]
    a0 = $signed({{(ANG_W-34){in_req.angle[19]}}, in_req.angle, 14'b0});
    if (a0 > PI_Q30)       a1_nxt = a0 - TWO_PI_Q30;
    else if (a0 < -PI_Q30) a1_nxt = a0 + TWO_PI_Q30;
    else                   a1_nxt = a0;
  end

  logic                    v0_r;
  payload_t                pl0_r;
  logic signed [ANG_W-1:0] a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    pl0_r <= pl_nxt;
    a1_r  <= a1_nxt;
  end

  // ---- Stage 1: fold into [-pi/2, pi/2], remember sign flip ----
  logic                    v1_r;
  payload_t                pl1_r;
  logic signed [ANG_W-1:0] a2_r;
  logic                    neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    pl1_r <= pl0_r;
    if (a1_r > HALF_PI_Q30) begin
      a2_r  <= a1_r - PI_Q30;
      neg_r <= 1'b1;
    end else if (a1_r < -HALF_PI_Q30) begin
      a2_r  <= a1_r + PI_Q30;
      neg_r <= 1'b1;
    end else begin
      a2_r  <= a1_r;
      neg_r <= 1'b0;
    end
  end

  // ---- CORDIC sin/cos, payload delayed alongside ----
  logic               cs_valid;
  logic signed [31:0] cos_w;
  logic signed [31:0] sin_w;

  p3at_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_angle  (a2_r),
    .in_neg    (neg_r),
    .out_valid (cs_valid),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  payload_t pld_r [DLY];

  always_ff @(posedge clk) begin
    pld_r[0] <= pl1_r;
    for (int k = 1; k < DLY; k++) begin
      pld_r[k] <= pld_r[k-1];
    end
  end

  // ---- Multiply, round, add reference back, saturate ----
  p3at_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cs_valid),
    .in_pl     (pld_r[DLY-1]),
    .cos_i     (cos_w),
    .sin_i     (sin_w),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

>>> hw/rtl/p3at_cordic.sv
module p3at_cordic #(
  parameter int STEPS = p3at_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [p3at_pkg::ANG_W-1:0] in_angle,
  input  logic                             in_neg,
  output logic                             out_valid,
  output logic signed [31:0]               cos_o,
  output logic signed [31:0]               sin_o
);
  import p3at_pkg::*;

  localparam int N = cordic_depth(STEPS);

  logic signed [CS_W-1:0]  x_r [1:N];
  logic signed [CS_W-1:0]  y_r [1:N];
  logic signed [ANG_W-1:0] z_r [1:N];
  logic                    neg_r [1:N];
  logic                    v_r [1:N];

  logic                    vo_r;
  logic signed [31:0]      cos_r;
  logic signed [31:0]      sin_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CS_W-1:0]  xi;
    logic signed [CS_W-1:0]  yi;
    logic signed [ANG_W-1:0] zi;
    logic                    ni;
    logic                    vi;
    logic signed [ANG_W-1:0] at;

    if (i == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = in_angle;
      assign ni = in_neg;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign zi = z_r[i];
      assign ni = neg_r[i];
      assign vi = v_r[i];
    end

    assign at = $signed({{(ANG_W-30){1'b0}}, atan_q30(i)});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= vi;
      end
      neg_r[i+1] <= ni;
      // rotate toward zero residual angle
      if (zi >= 0) begin
        x_r[i+1] <= xi - (yi >>> i);
        y_r[i+1] <= yi + (xi >>> i);
        z_r[i+1] <= zi - at;
      end else begin
        x_r[i+1] <= xi + (yi >>> i);
        y_r[i+1] <= yi - (xi >>> i);
        z_r[i+1] <= zi + at;
      end
    end
  end

  logic signed [CS_W-1:0] xf;
  logic signed [CS_W-1:0] yf;

  assign xf = neg_r[N] ? -x_r[N] : x_r[N];
  assign yf = neg_r[N] ? -y_r[N] : y_r[N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[N];
    end
    // clamp to +-1.0
    if (xf > ONE_Q30)       cos_r <= 32'(ONE_Q30);
    else if (xf < -ONE_Q30) cos_r <= -32'(ONE_Q30);
    else                    cos_r <= xf[31:0];
    if (yf > ONE_Q30)       sin_r <= 32'(ONE_Q30);
    else if (yf < -ONE_Q30) sin_r <= -32'(ONE_Q30);
    else                    sin_r <= yf[31:0];
  end

  assign out_valid = vo_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;

endmodule

>>> hw/rtl/p3at_mult.sv
module p3at_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  p3at_pkg::payload_t  in_pl,
  input  logic signed [31:0]  cos_i,
  input  logic signed [31:0]  sin_i,
  output logic                out_valid,
  output p3at_pkg::res_t      out_res
);
  import p3at_pkg::*;

  // Stage 1: products
  logic signed [PT_W-1:0] u;
  logic signed [PT_W-1:0] v;
  logic signed [PT_W-1:0] ma [4];
  logic signed [31:0]     mb [4];

  logic                   v1_r;
  payload_t               pl1_r;
  logic signed [PR_W-1:0] pr_r [4];

  always_comb begin
    u = in_pl.px;
    v = in_pl.py;
    case (in_pl.mode)
      MODE_ROT_X: begin
        u = in_pl.py;
        v = in_pl.pz;
      end
      MODE_ROT_Y: begin
        u = in_pl.px;
        v = in_pl.pz;
      end
      default: begin
        u = in_pl.px;
        v = in_pl.py;
      end
    endcase
    if (in_pl.mode == MODE_SCALE) begin
      ma[0] = in_pl.px; mb[0] = in_pl.ox;
      ma[1] = in_pl.py; mb[1] = in_pl.oy;
      ma[2] = in_pl.pz; mb[2] = in_pl.oz;
      ma[3] = '0;       mb[3] = '0;
    end else begin
      ma[0] = u; mb[0] = cos_i;
      ma[1] = v; mb[1] = sin_i;
      ma[2] = u; mb[2] = sin_i;
      ma[3] = v; mb[3] = cos_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    pl1_r <= in_pl;
    for (int k = 0; k < 4; k++) begin
      pr_r[k] <= PR_W'(ma[k]) * PR_W'(mb[k]);
    end
  end

  // Stage 2: sum, round, pick per coordinate
  logic signed [PR_W:0] su;
  logic signed [PR_W:0] sv;
  logic signed [PR_W:0] sc [3];
  logic signed [Q_W-1:0] ru;
  logic signed [Q_W-1:0] rv;
  logic signed [Q_W-1:0] qx_nxt;
  logic signed [Q_W-1:0] qy_nxt;
  logic signed [Q_W-1:0] qz_nxt;
  logic signed [Q_W-1:0] ex;
  logic signed [Q_W-1:0] ey;
  logic signed [Q_W-1:0] ez;

  logic                  v2_r;
  logic                  rel2_r;
  logic signed [31:0]    rx2_r;
  logic signed [31:0]    ry2_r;
  logic signed [31:0]    rz2_r;
  logic signed [Q_W-1:0] qx_r;
  logic signed [Q_W-1:0] qy_r;
  logic signed [Q_W-1:0] qz_r;

  always_comb begin
    su = (PR_W+1)'(pr_r[0]) - (PR_W+1)'(pr_r[1]) + (PR_W+1)'(64'sd536870912);
    sv = (PR_W+1)'(pr_r[2]) + (PR_W+1)'(pr_r[3]) + (PR_W+1)'(64'sd536870912);
    ru = Q_W'($signed(su[PR_W:30]));
    rv = Q_W'($signed(sv[PR_W:30]));
    for (int k = 0; k < 3; k++) begin
      sc[k] = (PR_W+1)'(pr_r[k]) + (PR_W+1)'(64'sd32768);
    end
    ex = Q_W'(pl1_r.px);
    ey = Q_W'(pl1_r.py);
    ez = Q_W'(pl1_r.pz);
    qx_nxt = ex;
    qy_nxt = ey;
    qz_nxt = ez;
    case (pl1_r.mode)
      MODE_ADD: begin
        qx_nxt = ex + Q_W'(pl1_r.ox);
        qy_nxt = ey + Q_W'(pl1_r.oy);
        qz_nxt = ez + Q_W'(pl1_r.oz);
      end
      MODE_ROT_X: begin
        qy_nxt = ru;
        qz_nxt = rv;
      end
      MODE_ROT_Y: begin
        qx_nxt = ru;
        qz_nxt = rv;
      end
      MODE_ROT_Z: begin
        qx_nxt = ru;
        qy_nxt = rv;
      end
      MODE_SCALE: begin
        qx_nxt = sc[0][PR_W:16];
        qy_nxt = sc[1][PR_W:16];
        qz_nxt = sc[2][PR_W:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    rel2_r <= pl1_r.rel;
    rx2_r  <= pl1_r.rx;
    ry2_r  <= pl1_r.ry;
    rz2_r  <= pl1_r.rz;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    qz_r   <= qz_nxt;
  end

  // Stage 3: shift back by reference, saturate
  function automatic logic signed [31:0] sat32(input logic signed [Q_W:0] a);
    logic signed [31:0] r;
    if (a > (Q_W+1)'(32'sh7fffffff))      r = 32'sh7fffffff;
    else if (a < -(Q_W+1)'(33'sh80000000)) r = 32'sh80000000;
    else                                  r = a[31:0];
    return r;
  endfunction

  logic signed [Q_W:0] fx;
  logic signed [Q_W:0] fy;
  logic signed [Q_W:0] fz;
  logic                vo_r;
  res_t                res_r;

  assign fx = (Q_W+1)'(qx_r) + (rel2_r ? (Q_W+1)'(rx2_r) : '0);
  assign fy = (Q_W+1)'(qy_r) + (rel2_r ? (Q_W+1)'(ry2_r) : '0);
  assign fz = (Q_W+1)'(qz_r) + (rel2_r ? (Q_W+1)'(rz2_r) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v2_r;
    end
    res_r.result_x <= sat32(fx);
    res_r.result_y <= sat32(fy);
    res_r.result_z <= sat32(fz);
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule

>>> hw/rtl/p3at_checker.sv
module p3at_checker #(
  parameter int CORDIC_STEPS = p3at_pkg::CORDIC_STEPS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input p3at_pkg::in_req_t in_req,
  input logic              out_valid,
  input p3at_pkg::res_t    out_res
);
  import p3at_pkg::*;

  localparam int LAT = core_latency(CORDIC_STEPS);

  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_valid_has_beat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, LAT))
    else $error("result strobe without matching start beat");

  a_unknown_pass : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && (in_req.req_type > 4'(OP_REL_SCALE)), LAT) |->
      out_res.result_x == $past(in_req.point_x, LAT) &&
      out_res.result_y == $past(in_req.point_y, LAT) &&
      out_res.result_z == $past(in_req.point_z, LAT))
    else $error("unknown code did not pass point through");

endmodule

bind point3d_affine_transform_core p3at_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_p3at_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import p3at_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int N_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 400000;

  localparam longint PI30  = 64'sd3373259426;
  localparam longint HPI30 = 64'sd1686629713;
  localparam longint TPI30 = 64'sd6746518852;
  localparam longint GAIN30 = 64'sd652032874;
  localparam longint ONE30 = 64'sd1073741824;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  res_t     out_res;
  longint   cycles = 0;

  point3d_affine_transform_core #(.CORDIC_STEPS(STEPS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // Floor shift, independent of the simulator's handling of signed >>>
  function automatic longint fshr(longint v, int sh);
    if (v < 0) return -64'sd1 - ((-64'sd1 - v) >> sh);
    return v >> sh;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                         524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                         2048, 1024, 512, 256, 128};
    return tbl[i];
  endfunction

  class point_scoreboard;
    res_t   pending[$];
    int     mismatches;

    // Fold angle into [-pi/2, pi/2], then run the CORDIC in Q.30
    function void sin_cos(longint ang16, output longint c, output longint s);
      longint a, x, y, nx;
      bit     flip;
      a = ang16 * 16384;
      x = GAIN30;
      y = 0;
      flip = 0;
      if (a > PI30) a -= TPI30;
      else if (a < -PI30) a += TPI30;
      if (a > HPI30) begin
        a -= PI30;
        flip = 1;
      end else if (a < -HPI30) begin
        a += PI30;
        flip = 1;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        if (a >= 0) begin
          nx = x - fshr(y, i);
          y = y + fshr(x, i);
          a -= arctan_step(i);
        end else begin
          nx = x + fshr(y, i);
          y = y - fshr(x, i);
          a += arctan_step(i);
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = sat(x, -ONE30, ONE30);
      s = sat(y, -ONE30, ONE30);
    endfunction

    function void note_beat(in_req_t r);
      longint p[3], o[3], rf[3], c, s, u, v;
      logic [3:0] op, kind;
      res_t e;
      op = r.req_type;
      p[0] = r.point_x;   p[1] = r.point_y;   p[2] = r.point_z;
      o[0] = r.operand_x; o[1] = r.operand_y; o[2] = r.operand_z;
      rf[0] = r.ref_x;    rf[1] = r.ref_y;    rf[2] = r.ref_z;
      c = 0;
      s = 0;
      kind = op;
      if (op >= OP_REL_ROT_X && op <= OP_REL_SCALE) begin
        for (int k = 0; k < 3; k++) p[k] -= rf[k];
        kind = op - 4'd4;
      end
      if (kind >= OP_ROT_X && kind <= OP_ROT_Z) sin_cos(longint'(r.angle), c, s);
      case (kind)
        OP_TRANSLATE: begin
          if (op == OP_TRANSLATE) for (int k = 0; k < 3; k++) p[k] += o[k];
        end
        OP_ROT_X, OP_ROT_Y, OP_ROT_Z: begin
          // Pair the two coordinates that move; products stay within 64 bits
          int iu, iv;
          iu = (kind == OP_ROT_X) ? 1 : 0;
          iv = (kind == OP_ROT_Z) ? 1 : 2;
          u = p[iu];
          v = p[iv];
          p[iu] = fshr(u * c - v * s + (64'sd1 <<< 29), 30);
          p[iv] = fshr(u * s + v * c + (64'sd1 <<< 29), 30);
        end
        OP_SCALE: begin
          for (int k = 0; k < 3; k++) p[k] = fshr(p[k] * o[k] + 64'sd32768, 16);
        end
        default: ;
      endcase
      if (op >= OP_REL_ROT_X && op <= OP_REL_SCALE)
        for (int k = 0; k < 3; k++) p[k] += rf[k];
      e.result_x = 32'(sat(p[0], -64'sd2147483648, 64'sd2147483647));
      e.result_y = 32'(sat(p[1], -64'sd2147483648, 64'sd2147483647));
      e.result_z = 32'(sat(p[2], -64'sd2147483648, 64'sd2147483647));
      pending.push_back(e);
    endfunction

    function void check_beat(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.result_x !== e.result_x || got.result_y !== e.result_y ||
          got.result_z !== e.result_z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                   e.result_x, e.result_y, e.result_z,
                   got.result_x, got.result_y, got.result_z);
      end
    endfunction
  endclass

  point_scoreboard sb;
  bit              calm;  // stretch with no sender idling

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample results at the rising edge; the core cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_beat(out_res);
    if (rst_n && start && !busy) sb.note_beat(in_req);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
      default: return $signed($urandom());
    endcase
  endfunction

  // Present one beat from the falling edge and hold it until accepted
  task automatic send_beat(in_req_t r);
    if (!calm && $urandom_range(0, 99) < 3) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic go_idle();
    start <= 1'b0;
  endtask

  function automatic in_req_t blank_req(logic [3:0] op);
    in_req_t r;
    r = '0;
    r.req_type = op;
    r.point_x = 32'sh00010000;
    r.point_y = 32'sh00020000;
    r.point_z = -32'sh00030000;
    r.operand_x = 32'sh00018000;
    r.operand_y = -32'sh00008000;
    r.operand_z = 32'sh00020000;
    r.ref_x = 32'sh00004000;
    r.ref_y = -32'sh00010000;
    r.ref_z = 32'sh00050000;
    r.angle = 20'sd102944;  // about pi/2
    return r;
  endfunction

  initial begin
    in_req_t r;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    calm = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every code, unknown codes, angle folds, saturation
    for (int op = 0; op < 16; op++) send_beat(blank_req(4'(op)));
    r = blank_req(OP_ROT_Z);
    r.angle = 20'sh7ffff;  send_beat(r);
    r.angle = 20'sh80000;  send_beat(r);
    r.angle = -20'sd102944; send_beat(r);
    r.angle = 20'sd205887;  send_beat(r);
    r = blank_req(OP_TRANSLATE);
    r.point_x = 32'sh7fffffff; r.operand_x = 32'sh7fffffff;
    r.point_y = 32'sh80000000; r.operand_y = 32'sh80000000;
    send_beat(r);
    r = blank_req(OP_SCALE);
    r.point_x = 32'sh7fffffff; r.operand_x = 32'sh80000000;
    r.point_y = 32'sh80000000; r.operand_y = 32'sh80000000;
    send_beat(r);
    r = blank_req(OP_REL_SCALE);
    r.point_x = 32'sh7fffffff; r.ref_x = 32'sh80000000; r.operand_x = 32'sh7fffffff;
    send_beat(r);
    r = blank_req(OP_REL_ROT_Y);
    r.point_z = 32'sh80000000; r.ref_z = 32'sh7fffffff; r.angle = 20'sh80000;
    send_beat(r);

    // Hold off until the pipeline drains
    go_idle();
    while (sb.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 500 && n < 800);
      r.req_type  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
      r.point_x   = pick32();
      r.point_y   = pick32();
      r.point_z   = pick32();
      r.operand_x = pick32();
      r.operand_y = pick32();
      r.operand_z = pick32();
      r.ref_x     = pick32();
      r.ref_y     = pick32();
      r.ref_z     = pick32();
      r.angle     = 20'($urandom());
      send_beat(r);
    end
    go_idle();

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (core_latency(STEPS) + 10) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
